@@ src/fmbq_pkg.sv @@
// Shared types and constants for the front/middle/back queue.
// Used by fmbq_cell and front_middle_back_queue; no dependencies.
package fmbq_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  // request codes
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_MID   = 3'd1;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd2;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd3;
  localparam logic [2:0] REQ_POP_MID    = 3'd4;
  localparam logic [2:0] REQ_POP_BACK   = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_REM
  } cell_op_e;

  // broadcast to every cell of the row
  typedef struct packed {
    cell_op_e           op;
    logic [IDX_W-1:0]   pos;
    logic [DATA_W-1:0]  value;
  } cell_ctrl_t;

endpackage

@@ src/front_middle_back_queue.sv @@
// Top level of the front/middle/back queue: count, request decode, result register.
// Depends on fmbq_pkg and fmbq_cell.
//
// Usage:
//   A request (req_type_i, value_i) is transferred at a rising edge with start_i
//   high and busy_o low. busy_o is always low, so a request may be issued in
//   every cycle.
//   Each request yields one result (data_o, status_o, occupancy_o) marked by
//   done_o, in the cycle after the transfer; it is shown for exactly one cycle.
//   Throughput is one request per cycle: the cells of the row all shift or hold
//   in the same cycle, and the popped value is picked from the cell taps
//   through an AND-OR select into the result register.
//   Pushes onto a full queue are dropped with status full; pops from an empty
//   queue return all ones with status empty. Codes 6 and 7 change nothing.
//   Reset clears the count and the result strobe; cell contents are left as
//   they are and only positions below the count are ever read.
//   The receiver cannot stall: a result not taken in its cycle is gone.
module front_middle_back_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [2:0]                  req_type_i,
  input  logic signed [31:0]          value_i,
  output logic                        done_o,
  output logic signed [31:0]          data_o,
  output logic [1:0]                  status_o,
  output logic [6:0]                  occupancy_o
);
  import fmbq_pkg::*;

  logic [CNT_W-1:0]  count_q, count_d;
  logic              done_q;
  logic [DATA_W-1:0] data_q, data_d;
  logic [1:0]        status_q, status_d;
  logic [CNT_W-1:0]  cnt_last;
  logic              is_full, is_empty;
  cell_ctrl_t        ctrl;
  logic [DATA_W-1:0] cell_q [DEPTH];
  logic [DATA_W-1:0] cell_tap [DEPTH];
  logic [DATA_W-1:0] popped;

  assign is_full  = (count_q == CNT_W'(DEPTH));
  assign is_empty = (count_q == '0);
  assign cnt_last = count_q - CNT_W'(1);

  always_comb begin
    ctrl.op    = OP_HOLD;
    ctrl.pos   = '0;
    ctrl.value = value_i;
    count_d    = count_q;
    status_d   = ST_OK;
    if (start_i) begin
      case (req_type_i)
        REQ_PUSH_FRONT, REQ_PUSH_MID, REQ_PUSH_BACK: begin
          if (is_full) begin
            status_d = ST_FULL;
          end else begin
            ctrl.op = OP_INS;
            count_d = count_q + CNT_W'(1);
            if (req_type_i == REQ_PUSH_MID) begin
              ctrl.pos = count_q[IDX_W:1];
            end else if (req_type_i == REQ_PUSH_BACK) begin
              ctrl.pos = count_q[IDX_W-1:0];
            end
          end
        end
        REQ_POP_FRONT, REQ_POP_MID, REQ_POP_BACK: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else begin
            ctrl.op = OP_REM;
            count_d = cnt_last;
            if (req_type_i == REQ_POP_MID) begin
              ctrl.pos = cnt_last[IDX_W:1];
            end else if (req_type_i == REQ_POP_BACK) begin
              ctrl.pos = cnt_last[IDX_W-1:0];
            end
          end
        end
        default: status_d = ST_OK;
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_q[i+1];
    end
    fmbq_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .idx_i   (IDX_W'(i)),
      .left_i  (left),
      .right_i (right),
      .q_o     (cell_q[i]),
      .tap_o   (cell_tap[i])
    );
  end

  // only the removed cell drives its tap
  always_comb begin
    popped = '0;
    for (int i = 0; i < DEPTH; i++) begin
      popped = popped | cell_tap[i];
    end
  end

  always_comb begin
    data_d = '0;
    if (status_d == ST_EMPTY) begin
      data_d = '1;
    end else if (ctrl.op == OP_REM) begin
      data_d = popped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q   <= data_d;
    status_q <= status_d;
  end

  assign busy_o      = 1'b0;
  assign done_o      = done_q;
  assign data_o      = data_q;
  assign status_o    = status_q;
  assign occupancy_o = 7'(count_q);

endmodule

@@ src/fmbq_cell.sv @@
// One storage cell of the queue row: holds, shifts from a neighbor or loads.
// Depends on fmbq_pkg.
module fmbq_cell (
  input  logic                       clk_i,
  input  fmbq_pkg::cell_ctrl_t       ctrl_i,
  input  logic [fmbq_pkg::IDX_W-1:0] idx_i,
  input  logic [fmbq_pkg::DATA_W-1:0] left_i,
  input  logic [fmbq_pkg::DATA_W-1:0] right_i,
  output logic [fmbq_pkg::DATA_W-1:0] q_o,
  output logic [fmbq_pkg::DATA_W-1:0] tap_o
);
  import fmbq_pkg::*;

  logic [DATA_W-1:0] val_q, val_d;

  always_comb begin
    val_d = val_q;
    case (ctrl_i.op)
      OP_INS: begin
        // open the gap: cells past the insert point take the left neighbor
        if (idx_i > ctrl_i.pos) begin
          val_d = left_i;
        end else if (idx_i == ctrl_i.pos) begin
          val_d = ctrl_i.value;
        end
      end
      OP_REM: begin
        // close the gap from the right
        if (idx_i >= ctrl_i.pos) begin
          val_d = right_i;
        end
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign q_o   = val_q;
  assign tap_o = (ctrl_i.op == OP_REM && idx_i == ctrl_i.pos) ? val_q : '0;

endmodule
